// File: design/ntlc_pkg.sv
// Shared types and constants for the track linker and line-crossing counter.
package ntlc_pkg;

    localparam int HistDepth = 64;
    localparam int MaxTracks = 64;
    localparam int HistW     = $clog2(HistDepth);
    localparam int TrackW    = $clog2(MaxTracks);

    localparam logic [2:0] REG_LINE_Y    = 3'd0;
    localparam logic [2:0] REG_LINE_X    = 3'd1;
    localparam logic [2:0] REG_TRAIL     = 3'd2;
    localparam logic [2:0] REG_WINDOW    = 3'd3;
    localparam logic [2:0] REG_MATCH     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_TRACK,
        ST_UPDATE,
        ST_OUT
    } t_state;

    // Token passed along the cell chain during a scan.
    typedef struct packed {
        logic        found;
        logic [25:0] best;
        logic [HistW-1:0] slot;
    } t_best;

    typedef struct packed {
        logic [11:0] line_y;
        logic [11:0] line_x;
        logic [7:0]  trail;
        logic [7:0]  window;
        logic [15:0] match;
    } t_cfg;

    function automatic logic [11:0] center_of(input logic [11:0] pos, input logic [11:0] size);
        logic [13:0] s;
        logic [12:0] c;
        s = {1'b0, pos, 1'b0} + {2'b00, size};
        c = s[13:1];
        if (s[0]) c = c + {12'd0, c[0]};
        return (c > 13'd4095) ? 12'd4095 : c[11:0];
    endfunction

endpackage

// File: design/ntlc_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface ntlc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_width;
    logic [11:0] rect_height;
    modport source (output valid, kind, rect_x, rect_y, rect_width, rect_height, input ready);
    modport sink (input valid, kind, rect_x, rect_y, rect_width, rect_height, output ready);
endinterface

interface ntlc_out_if;
    logic        valid;
    logic        ready;
    logic        linked;
    logic [5:0]  track_id;
    logic        newly_crossed;
    logic [15:0] people_count;
    modport source (output valid, linked, track_id, newly_crossed, people_count, input ready);
    modport sink (input valid, linked, track_id, newly_crossed, people_count, output ready);
endinterface

interface ntlc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/nearest_track_line_cross_counter_core.sv
// Top level: request FSM, scan over the chain of history cells, track table.
// Usage: requests arrive on i_in (kind 1 = frame tick, 0 = detection).
// Every request gives exactly one result on o_out, in request order.
// A frame tick goes straight to the result load; input reopens once the
// result is in the output register.
// A detection passes the best-match token down the chain of HistDepth cells,
// one cell per cycle, every cell holding one history entry; the scan is
// followed by a read, a track table access, an update and the result load.
// One request is in work at a time; i_in.ready is high only when idle.
// Register writes on i_cfg are taken at any time and are meant for idle.
// Reset (synchronous, active low) clears history valid bits, ring pointer,
// next track id, frame number, the count and the output valid bit. Track
// table entries of a new track are read, but used only once a link has set them.
// When o_out.ready is low the result waits in the output register while the
// next request is taken and worked on; that one waits in its last step until
// the register is free, and no further request is taken meanwhile.
module nearest_track_line_cross_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ntlc_in_if.sink     i_in,
    ntlc_out_if.source  o_out,
    ntlc_cfg_if.sink    i_cfg
);
    import ntlc_pkg::*;

    t_state r_state, n_state;
    t_cfg   r_cfg;
    logic [11:0] r_cx, r_cy;
    logic [15:0] r_frame_no;
    logic [15:0] r_count;
    logic [HistW-1:0] r_ptr;
    logic [TrackW-1:0] r_next;
    logic [HistW:0]    r_k;
    t_best  r_tok;
    logic   r_link;
    logic [TrackW-1:0] r_id;
    logic   r_newtrk;
    logic [11:0] r_px, r_py;
    logic   r_crossed;
    logic [7:0] r_len;
    logic   r_ov_linked, r_ov_cross;
    logic [TrackW-1:0] r_ov_id;
    logic   r_res_valid, r_res_linked, r_res_cross;
    logic [TrackW-1:0] r_res_id;
    logic [15:0] r_res_count;
    logic   res_free, res_load;

    logic              r_tcross [MaxTracks];
    logic [7:0]        r_tlen [MaxTracks];

    t_best             tok [HistDepth+1];
    logic [11:0]       cx_a [HistDepth];
    logic [11:0]       cy_a [HistDepth];
    logic              has_a [HistDepth];
    logic [TrackW-1:0] trk_a [HistDepth];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign res_free    = !r_res_valid || o_out.ready;
    assign res_load    = (r_state == ST_OUT) && res_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{line_y: 12'd100, line_x: 12'd80, trail: 8'd5,
                       window: 8'd20, match: 16'd1000};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_LINE_Y: r_cfg.line_y <= i_cfg.data[11:0];
                REG_LINE_X: r_cfg.line_x <= i_cfg.data[11:0];
                REG_TRAIL:  r_cfg.trail  <= i_cfg.data[7:0];
                REG_WINDOW: r_cfg.window <= i_cfg.data[7:0];
                REG_MATCH:  r_cfg.match  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign tok[0] = '0;
    genvar g;
    generate
        for (g = 0; g < HistDepth; g++) begin : g_cell
            ntlc_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_slot(HistW'(g)),
                .i_ptr(r_ptr),
                .i_clear(r_newtrk),
                .i_wr(r_state == ST_UPDATE && r_ptr == HistW'(g)),
                .i_wx(r_cx), .i_wy(r_cy), .i_wframe(r_frame_no),
                .i_whas(r_link), .i_wtrack(r_link ? r_id : '0),
                .i_use(r_state == ST_TRACK && r_link && r_tok.slot == HistW'(g)),
                .i_score(r_state == ST_SCAN),
                .i_cx(r_cx), .i_cy(r_cy), .i_frame(r_frame_no),
                .i_window(r_cfg.window),
                .i_tok(tok[g]), .o_tok(tok[g+1]),
                .o_x(cx_a[g]), .o_y(cy_a[g]), .o_has(has_a[g]), .o_track(trk_a[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = i_in.kind ? ST_OUT : ST_SCAN;
            ST_SCAN:   if (r_k == (HistW+1)'(HistDepth)) n_state = ST_READ;
            ST_READ:   n_state = ST_TRACK;
            ST_TRACK:  n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_OUT;
            ST_OUT:    if (res_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    logic [7:0]  len_n;
    logic        cross_hit, cross_now, bump;
    always_comb begin
        len_n     = r_newtrk ? 8'd1 : ((r_len < 8'd255) ? r_len + 8'd1 : r_len);
        cross_hit = (r_py < r_cfg.line_y && r_cy >= r_cfg.line_y)
                 || (r_py > r_cfg.line_y && r_cy <= r_cfg.line_y)
                 || (r_px < r_cfg.line_x && r_cx >= r_cfg.line_x)
                 || (r_px > r_cfg.line_x && r_cx <= r_cfg.line_x);
        cross_now = cross_hit && (r_newtrk || !r_crossed);
        bump      = 1'b0;
        if (!r_newtrk && r_len < 8'd255 && r_crossed && len_n == r_cfg.trail) bump = 1'b1;
        if (cross_now && len_n > r_cfg.trail) bump = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_frame_no <= '0;
            r_count    <= '0;
            r_ptr      <= '0;
            r_next     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_in.valid && i_in.kind)
                r_frame_no <= r_frame_no + 16'd1;
            if (r_state == ST_TRACK && r_link) begin
                if (r_newtrk) r_next <= r_id + TrackW'(1);
                if (bump && r_count != 16'hFFFF) r_count <= r_count + 16'd1;
            end
            if (r_state == ST_UPDATE) r_ptr <= r_ptr + HistW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_cx   <= center_of(i_in.rect_x, i_in.rect_width);
                r_cy   <= center_of(i_in.rect_y, i_in.rect_height);
                r_k    <= '0;
                r_tok  <= '0;
                r_ov_linked <= 1'b0;
                r_ov_cross  <= 1'b0;
                r_ov_id     <= '0;
                r_link <= 1'b0;
                r_id   <= '0;
            end
            ST_SCAN: begin
                r_tok <= tok[HistDepth];
                r_k   <= r_k + (HistW+1)'(1);
            end
            ST_READ: begin
                r_link   <= r_tok.found && r_tok.best < {10'd0, r_cfg.match};
                r_px     <= cx_a[r_tok.slot];
                r_py     <= cy_a[r_tok.slot];
                r_newtrk <= !has_a[r_tok.slot];
                r_id     <= has_a[r_tok.slot] ? trk_a[r_tok.slot] : r_next;
                r_crossed <= r_tcross[has_a[r_tok.slot] ? trk_a[r_tok.slot] : r_next];
                r_len     <= r_tlen[has_a[r_tok.slot] ? trk_a[r_tok.slot] : r_next];
            end
            ST_TRACK: begin
                if (r_link) begin
                    r_tlen[r_id] <= len_n;
                    if (r_newtrk || cross_now) r_tcross[r_id] <= cross_now;
                    r_ov_linked <= 1'b1;
                    r_ov_id     <= r_id;
                    r_ov_cross  <= cross_now;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_linked <= r_ov_linked;
            r_res_id     <= r_ov_id;
            r_res_cross  <= r_ov_cross;
            r_res_count  <= r_count;
        end
    end

    assign o_out.valid         = r_res_valid;
    assign o_out.linked        = r_res_linked;
    assign o_out.track_id      = r_res_id;
    assign o_out.newly_crossed = r_res_cross;
    assign o_out.people_count  = r_res_count;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.track_id)
            && $stable(o_out.people_count))) else $error("result changed while stalled");
    a_tick_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.kind) |=> r_frame_no == $past(r_frame_no) + 16'd1)
        else $error("frame tick lost");
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> r_ptr == $past(r_ptr) + HistW'(1))
        else $error("ring pointer slip");
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count)) else $error("count went down");
    a_cross_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.newly_crossed) |-> o_out.linked)
        else $error("crossing without link");
endmodule

// File: design/ntlc_cell.sv
// One history cell: holds an entry, scores it and passes the best token on.
module ntlc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ntlc_pkg::HistW-1:0] i_slot,
    input  logic [ntlc_pkg::HistW-1:0] i_ptr,
    input  logic                  i_clear,
    input  logic                  i_wr,
    input  logic [11:0]           i_wx,
    input  logic [11:0]           i_wy,
    input  logic [15:0]           i_wframe,
    input  logic                  i_whas,
    input  logic [ntlc_pkg::TrackW-1:0] i_wtrack,
    input  logic                  i_use,
    input  logic                  i_score,
    input  logic [11:0]           i_cx,
    input  logic [11:0]           i_cy,
    input  logic [15:0]           i_frame,
    input  logic [7:0]            i_window,
    input  ntlc_pkg::t_best       i_tok,
    output ntlc_pkg::t_best       o_tok,
    output logic [11:0]           o_x,
    output logic [11:0]           o_y,
    output logic                  o_has,
    output logic [ntlc_pkg::TrackW-1:0] o_track
);
    import ntlc_pkg::*;

    logic [11:0] r_x, r_y;
    logic [15:0] r_frame;
    logic        r_valid, r_used, r_has;
    logic [TrackW-1:0] r_track;
    logic [15:0] age;
    logic [11:0] dx, dy;
    logic [23:0] dx2, dy2;
    logic [25:0] d;
    logic        ok;
    logic [HistW-1:0] rank_me, rank_tok;
    t_best       n_tok, r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_used  <= 1'b0;
            r_has   <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
            r_used  <= 1'b0;
            r_has   <= i_whas;
        end else if (i_use) begin
            r_used <= 1'b1;
            if (i_clear) r_has <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_x     <= i_wx;
            r_y     <= i_wy;
            r_frame <= i_wframe;
            r_track <= i_wtrack;
        end else if (i_use && i_clear) begin
            r_track <= i_wtrack;
        end
    end

    // rank: position in oldest-first order, breaks distance ties
    always_comb begin
        age      = i_frame - r_frame;
        dx       = (i_cx > r_x) ? i_cx - r_x : r_x - i_cx;
        dy       = (i_cy > r_y) ? i_cy - r_y : r_y - i_cy;
        dx2      = 24'(dx) * 24'(dx);
        dy2      = 24'(dy) * 24'(dy);
        d        = {2'b00, dx2} + {2'b00, dy2} + {10'd0, 16'(age[7:0]) * 16'(age[7:0])};
        rank_me  = i_slot - i_ptr;
        rank_tok = i_tok.slot - i_ptr;
        ok       = r_valid && !r_used && age != 16'd0 && age <= {8'd0, i_window};
        n_tok    = i_tok;
        if (ok && (!i_tok.found || d < i_tok.best
                   || (d == i_tok.best && rank_me < rank_tok))) begin
            n_tok.found = 1'b1;
            n_tok.best  = d;
            n_tok.slot  = i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_score) r_tok <= n_tok;
    end

    assign o_tok   = r_tok;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_has   = r_has;
    assign o_track = r_track;
endmodule

// File: tb/ntlc_tb_checker.sv
// Checker: watches request, result and register channels, predicts and compares results.
module ntlc_tb_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ntlc_in_if.sink    i_in,
    ntlc_out_if.sink   i_out,
    ntlc_cfg_if.sink   i_cfg,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ntlc_pkg::*;

    typedef struct packed {
        logic        linked;
        logic [5:0]  track_id;
        logic        newly_crossed;
        logic [15:0] people_count;
    } t_track_res;

    t_track_res  res_q[$];
    t_cfg        cfg;
    logic [11:0] hx [HistDepth];
    logic [11:0] hy [HistDepth];
    logic [15:0] hf [HistDepth];
    logic        hv [HistDepth];
    logic        hu [HistDepth];
    logic        hht[HistDepth];
    logic [5:0]  htr[HistDepth];
    logic        tcross[MaxTracks];
    logic [7:0]  tlen[MaxTracks];
    logic [5:0]  rptr, nxt;
    logic [15:0] frame, total;

    function automatic logic [11:0] mid(input logic [11:0] p, input logic [11:0] sz);
        logic [13:0] s;
        logic [12:0] c;
        s = 14'(p) * 2 + 14'(sz);
        c = s[13:1];
        if (s[0] && c[0]) c = c + 1;
        return (c > 13'd4095) ? 12'd4095 : c[11:0];
    endfunction

    task automatic bump();
        if (total != 16'hFFFF) total = total + 1;
    endtask

    task automatic link_detection(input logic [11:0] x, y, w, h);
        logic [11:0] cx, cy, px, py;
        logic [15:0] age;
        int unsigned d, best, dx, dy;
        int bslot, slot;
        bit found;
        t_track_res r;
        r = '0;
        found = 0; best = 0; bslot = 0;
        cx = mid(x, w);
        cy = mid(y, h);
        for (int k = 0; k < HistDepth; k++) begin
            slot = (rptr + k) % HistDepth;
            if (!hv[slot] || hu[slot]) continue;
            age = frame - hf[slot];
            if (age < 1 || age > cfg.window) continue;
            dx = cx > hx[slot] ? cx - hx[slot] : hx[slot] - cx;
            dy = cy > hy[slot] ? cy - hy[slot] : hy[slot] - cy;
            d = dx * dx + dy * dy + age * age;
            if (!found || d < best) begin
                found = 1; best = d; bslot = slot;
            end
        end
        if (found && best < cfg.match) begin
            px = hx[bslot]; py = hy[bslot];
            r.linked = 1;
            hu[bslot] = 1;
            if (!hht[bslot]) begin
                r.track_id = nxt;
                nxt = nxt + 1;
                tcross[r.track_id] = 0;
                tlen[r.track_id] = 1;
                hht[bslot] = 1;
                htr[bslot] = r.track_id;
            end else begin
                r.track_id = htr[bslot];
                if (tlen[r.track_id] != 8'hFF) begin
                    tlen[r.track_id] = tlen[r.track_id] + 1;
                    if (tcross[r.track_id] && tlen[r.track_id] == cfg.trail) bump();
                end
            end
            if ((py < cfg.line_y && cy >= cfg.line_y) || (py > cfg.line_y && cy <= cfg.line_y)
                || (px < cfg.line_x && cx >= cfg.line_x)
                || (px > cfg.line_x && cx <= cfg.line_x)) begin
                if (!tcross[r.track_id]) begin
                    tcross[r.track_id] = 1;
                    r.newly_crossed = 1;
                    if (tlen[r.track_id] > cfg.trail) bump();
                end
            end
        end
        hx[rptr] = cx; hy[rptr] = cy; hf[rptr] = frame;
        hv[rptr] = 1; hu[rptr] = 0; hht[rptr] = r.linked; htr[rptr] = r.track_id;
        rptr = rptr + 1;
        r.people_count = total;
        res_q = {res_q, r};
    endtask

    always @(posedge i_clk) begin
        t_track_res e;
        if (!i_rst_n) begin
            cfg <= '{line_y: 12'd100, line_x: 12'd80, trail: 8'd5, window: 8'd20,
                     match: 16'd1000};
            for (int i = 0; i < HistDepth; i++) begin
                hv[i] = 0; hu[i] = 0; hht[i] = 0;
            end
            rptr = 0; nxt = 0; frame = 0; total = 0;
            res_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_LINE_Y: cfg.line_y <= i_cfg.data[11:0];
                    REG_LINE_X: cfg.line_x <= i_cfg.data[11:0];
                    REG_TRAIL:  cfg.trail  <= i_cfg.data[7:0];
                    REG_WINDOW: cfg.window <= i_cfg.data[7:0];
                    REG_MATCH:  cfg.match  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (res_q.size() == 0) begin
                    $error("result with no pending request");
                    o_errors <= o_errors + 1;
                end else begin
                    e = res_q.pop_front();
                    if (e.linked !== i_out.linked) begin
                        $error("linked: expected %0d actual %0d", e.linked, i_out.linked);
                        o_errors <= o_errors + 1;
                    end else if (e.track_id !== i_out.track_id) begin
                        $error("track_id: expected %0d actual %0d", e.track_id,
                               i_out.track_id);
                        o_errors <= o_errors + 1;
                    end else if (e.newly_crossed !== i_out.newly_crossed) begin
                        $error("newly_crossed: expected %0d actual %0d", e.newly_crossed,
                               i_out.newly_crossed);
                        o_errors <= o_errors + 1;
                    end else if (e.people_count !== i_out.people_count) begin
                        $error("people_count: expected %0d actual %0d", e.people_count,
                               i_out.people_count);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.kind) begin
                    frame = frame + 1;
                    e = '0;
                    e.people_count = total;
                    res_q = {res_q, e};
                end else begin
                    link_detection(i_in.rect_x, i_in.rect_y, i_in.rect_width,
                                   i_in.rect_height);
                end
            end
            o_pending <= res_q.size();
        end
    end
endmodule

// File: tb/tb_nearest_track_line_cross_counter_core.sv
// Testbench top: clock, reset, request and register stimulus, final verdict.
module tb_nearest_track_line_cross_counter_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ntlc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    int   cycles;
    bit   calm;
    bit   long_hold;

    ntlc_in_if  req_ch();
    ntlc_out_if res_ch();
    ntlc_cfg_if cfg_ch();

    nearest_track_line_cross_counter_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .o_out(res_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    ntlc_tb_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(req_ch.sink), .i_out(res_ch.sink),
        .i_cfg(cfg_ch.sink), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long hold
    initial begin
        int n;
        res_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                res_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                res_ch.ready <= 0;
                repeat (n) @(posedge i_clk);
            end
            res_ch.ready <= 1;
        end
    end

    task automatic send(input logic k, input logic [11:0] x, y, w, h);
        req_ch.valid <= 1;
        req_ch.kind <= k;
        req_ch.rect_x <= x; req_ch.rect_y <= y;
        req_ch.rect_width <= w; req_ch.rect_height <= h;
        do @(posedge i_clk); while (!req_ch.ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
    endtask

    task automatic drain();
        req_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic settings(input logic [11:0] ly, lx, input logic [7:0] tr, win,
                            input logic [15:0] md);
        write_reg(REG_LINE_Y, 16'(ly));
        write_reg(REG_LINE_X, 16'(lx));
        write_reg(REG_TRAIL, 16'(tr));
        write_reg(REG_WINDOW, 16'(win));
        write_reg(REG_MATCH, md);
    endtask

    // a walker moving across the lines with random noise between
    task automatic walk_phase(input int count);
        int x0, y0, dx, dy;
        x0 = $urandom_range(0, 200); y0 = $urandom_range(0, 200);
        dx = $urandom_range(0, 12) - 6; dy = $urandom_range(0, 12) - 6;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send(0, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            end else if ($urandom_range(0, 3) == 0) begin
                send(1, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            end else begin
                if (x0 < 10 || x0 > 4000 || $urandom_range(0, 15) == 0) begin
                    x0 = $urandom_range(0, 200); y0 = $urandom_range(0, 200);
                    dx = $urandom_range(0, 12) - 6; dy = $urandom_range(0, 12) - 6;
                end
                send(0, 12'(x0 + $urandom_range(0, 2)), 12'(y0 + $urandom_range(0, 2)),
                     12'($urandom_range(0, 20)), 12'($urandom_range(0, 20)));
                x0 += dx; y0 += dy;
                if (y0 < 0) y0 = 0;
                if ($urandom_range(0, 1)) send(1, 0, 0, 0, 0);
            end
        end
    endtask

    initial begin
        calm = 0;
        long_hold = 0;
        i_rst_n = 0;
        req_ch.valid = 0; req_ch.kind = 0;
        req_ch.rect_x = 0; req_ch.rect_y = 0; req_ch.rect_width = 0; req_ch.rect_height = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, rounding, linking, crossings at reset settings
        send(0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send(0, 0, 0, 0, 0);
        send(0, 3, 3, 1, 1);
        send(0, 2, 2, 1, 3);
        send(1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send(0, 70, 90, 10, 10);
        send(1, 0, 0, 0, 0);
        send(0, 80, 100, 10, 10);
        send(1, 0, 0, 0, 0);
        send(0, 90, 110, 10, 10);
        send(1, 0, 0, 0, 0);
        send(0, 75, 95, 10, 10);
        send(1, 0, 0, 0, 0);
        send(0, 70, 90, 10, 10);
        send(1, 0, 0, 0, 0);
        send(0, 80, 100, 10, 10);
        send(0, 0, 0, 0, 0);
        drain();

        settings(12'd0, 12'd4095, 8'd0, 8'd255, 16'hFFFF);
        walk_phase(75);
        drain();
        settings(12'd4095, 12'd0, 8'd255, 8'd1, 16'd1);
        walk_phase(45);
        drain();
        settings(12'd100, 12'd100, 8'd2, 8'd0, 16'd5000);
        walk_phase(30);
        drain();
        settings(12'd60, 12'd90, 8'd3, 8'd4, 16'd3000);
        long_hold = 1;
        walk_phase(120);
        drain();
        settings(12'($urandom_range(0, 200)), 12'($urandom_range(0, 200)),
                 8'($urandom_range(0, 8)), 8'($urandom_range(1, 30)),
                 16'($urandom_range(100, 20000)));
        walk_phase(120);
        calm = 1;
        walk_phase(45);
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
